/* rtl/core/sfr_pkg.sv */
package sfr_pkg;

  // defaults for the top level parameters
  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  // fixed field and register widths
  localparam int BEAT_BYTES = 8;
  localparam int BYTES_W    = 8 * BEAT_BYTES;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = 3;
  localparam int LEN_W      = 4;
  localparam int TOTAL_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  // input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               out_last;
    logic [TOTAL_W-1:0] match_count;
  } out_beat_t;

  // command from front to back: up to eight bytes to emit
  typedef struct packed {
    logic [BEAT_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]           cnt;
    logic                       last;
    logic [TOTAL_W-1:0]         total;
  } sfr_cmd_t;

endpackage

/* rtl/core/sfr_stream_if.sv */
// input channel
interface sfr_in_if;
  logic               valid;
  logic               ready;
  sfr_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface sfr_out_if;
  logic               valid;
  logic               ready;
  sfr_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/sfr_front.sv */
module sfr_front #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  sfr_in_if.sink                          in_chan,
  input  logic                            q_ready,
  output logic                            q_push,
  output sfr_pkg::sfr_cmd_t               q_cmd
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [MAX_PATTERN-1:0][7:0]      pat_bytes_r;
  logic [sfr_pkg::LEN_W-1:0]        pat_len_r;
  logic [MAX_REPLACEMENT-1:0][7:0]  rep_bytes_r;
  logic [sfr_pkg::LEN_W-1:0]        rep_len_r;

  // window and stream state
  logic [MAX_PATTERN-1:0][7:0]      win_r, win_nxt;
  logic [FILL_W-1:0]                fill_r, fill_nxt;
  logic [sfr_pkg::TOTAL_W-1:0]      total_r, total_nxt, total_inc;

  logic [FILL_W-1:0]                len_l;
  logic [sfr_pkg::CNT_W-1:0]        rep_l;
  logic [FILL_W-1:0]                eff_fill, nfill;
  logic [MAX_PATTERN-1:0][7:0]      cand;
  logic                             full_w, pat_eq, hit, accept;
  sfr_pkg::sfr_cmd_t                cmd;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = q_ready;

  // effective lengths, clamped to the maxima
  assign len_l = (pat_len_r > sfr_pkg::LEN_W'(MAX_PATTERN)) ?
                 FILL_W'(MAX_PATTERN) : FILL_W'(pat_len_r);
  assign rep_l = (rep_len_r > sfr_pkg::LEN_W'(MAX_REPLACEMENT)) ?
                 sfr_pkg::CNT_W'(MAX_REPLACEMENT) : sfr_pkg::CNT_W'(rep_len_r);

  // window with the new byte placed at the fill position
  always_comb begin
    eff_fill = (fill_r >= len_l) ? '0 : fill_r;
    nfill    = eff_fill + FILL_W'(1);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cand[k] = (FILL_W'(k) == eff_fill) ? in_chan.data.in_byte : win_r[k];
    end
  end

  // pattern compare over the first len_l bytes
  always_comb begin
    pat_eq = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (FILL_W'(k) < len_l && cand[k] != pat_bytes_r[k]) begin
        pat_eq = 1'b0;
      end
    end
  end

  assign full_w    = (len_l != '0) && (nfill == len_l);
  assign hit       = full_w && pat_eq;
  assign total_inc = (hit && total_r != '1) ? total_r + sfr_pkg::TOTAL_W'(1) : total_r;

  // classify the byte into a command and next window state
  always_comb begin
    cmd       = '0;
    cmd.bytes = sfr_pkg::BYTES_W'(cand);
    win_nxt   = cand;
    fill_nxt  = nfill;
    total_nxt = total_inc;
    if (len_l == '0) begin
      cmd.cnt  = sfr_pkg::CNT_W'(1);
      fill_nxt = '0;
    end else if (hit) begin
      cmd.bytes = sfr_pkg::BYTES_W'(rep_bytes_r);
      cmd.cnt   = rep_l;
      fill_nxt  = '0;
    end else if (full_w) begin
      // miss: the oldest byte leaves, the rest too at end of stream
      cmd.cnt  = in_chan.data.in_last ? sfr_pkg::CNT_W'(len_l) : sfr_pkg::CNT_W'(1);
      win_nxt  = cand >> 8;
      fill_nxt = len_l - FILL_W'(1);
    end else begin
      cmd.cnt = in_chan.data.in_last ? sfr_pkg::CNT_W'(nfill) : '0;
    end
    if (in_chan.data.in_last) begin
      cmd.last  = 1'b1;
      cmd.total = total_inc;
      fill_nxt  = '0;
      total_nxt = '0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.cnt != '0 || cmd.last);

  // configuration writes and stream control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= sfr_pkg::LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      fill_r      <= '0;
      total_r     <= '0;
    end else if (cfg_we) begin
      case (sfr_pkg::cfg_reg_t'(cfg_index))
        sfr_pkg::REG_PATTERN_BYTES:      pat_bytes_r <= cfg_data[8*MAX_PATTERN-1:0];
        sfr_pkg::REG_PATTERN_LENGTH:     pat_len_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_data[8*MAX_REPLACEMENT-1:0];
        sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
      fill_r  <= '0;
      total_r <= '0;
    end else if (accept) begin
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  // the window never holds a full pattern between beats
  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 || fill_r < len_l)
    else $error("window fill reached pattern length");

endmodule

/* rtl/core/sfr_queue.sv */
module sfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_cmd_t push_cmd,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output sfr_pkg::sfr_cmd_t pop_cmd
);

  sfr_pkg::sfr_cmd_t             mem_r [sfr_pkg::QDEPTH];
  logic [sfr_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [sfr_pkg::QCNT_W-1:0]    cnt_r;

  assign ready   = cnt_r != sfr_pkg::QCNT_W'(sfr_pkg::QDEPTH);
  assign valid   = cnt_r != '0;
  assign pop_cmd = mem_r[rd_ptr_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sfr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sfr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + sfr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - sfr_pkg::QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sfr_pkg::QCNT_W'(sfr_pkg::QDEPTH))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("command queue popped while empty");

endmodule

/* rtl/core/sfr_back.sv */
module sfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sfr_pkg::sfr_cmd_t q_cmd,
  output logic              q_pop,
  sfr_out_if.source         out_chan
);

  sfr_pkg::sfr_cmd_t          cur_r;
  logic                       cur_valid_r;
  logic [sfr_pkg::IDX_W-1:0]  idx_r;
  logic                       last_beat, fire, fin, bv;

  assign last_beat = (cur_r.cnt == '0) ||
                     (sfr_pkg::CNT_W'(idx_r) + sfr_pkg::CNT_W'(1) == cur_r.cnt);
  assign fire      = out_chan.valid && out_chan.ready;
  assign fin       = fire && last_beat;
  assign q_pop     = q_valid && (!cur_valid_r || fin);

  // result beat from the current command
  assign bv                        = cur_r.cnt != '0;
  assign out_chan.valid            = cur_valid_r;
  assign out_chan.data.byte_valid  = bv;
  assign out_chan.data.out_byte    = bv ? cur_r.bytes[idx_r] : 8'h00;
  assign out_chan.data.out_last    = cur_r.last && last_beat;
  assign out_chan.data.match_count = (cur_r.last && last_beat) ? cur_r.total : '0;

  // command register and beat index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (fin) begin
      cur_valid_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + sfr_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.cnt == '0 || sfr_pkg::CNT_W'(idx_r) < cur_r.cnt))
    else $error("beat index past command length");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.data.byte_valid) |-> out_chan.data.out_last)
    else $error("empty beat that is not the final one");

endmodule

/* rtl/core/stream_find_replace_top.sv */
// Streaming find-and-replace over bytes. The front takes one input beat per cycle
// while the two-entry command queue has room; it compares the window of held bytes
// (up to MAX_PATTERN) with the pattern and queues a command of up to eight bytes
// to emit. The back sends one result beat per cycle while the receiver is ready,
// so the output beat port is the limit: a passed byte gives one result beat, a
// match gives replacement_length beats, and the final byte can flush up to
// pattern_length beats. A command is written into the queue and then loaded into
// the back's command register, which drives the result beats. Configuration
// writes clear the window and the match count.
module stream_find_replace_top #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  sfr_in_if.sink                          in_chan,
  sfr_out_if.source                       out_chan
);

  logic              q_ready, q_push, q_valid, q_pop;
  sfr_pkg::sfr_cmd_t push_cmd, pop_cmd;

  // classify and queue
  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  // emit result beats
  sfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  // find-and-replace predictor plus the queue of result beats still owed
  class replace_checker;
    logic [63:0]          pattern;
    logic [3:0]           pat_len;
    logic [63:0]          replacement;
    logic [3:0]           rep_len;
    logic [7:0]           window [8];
    int unsigned          fill;
    logic [31:0]          total;
    sfr_pkg::out_beat_t   expected_beats [$];
    int                   mismatches;

    function new();
      pattern     = '0;
      pat_len     = 4'd1;
      replacement = '0;
      rep_len     = 4'd0;
      fill        = 0;
      total       = '0;
      mismatches  = 0;
    endfunction

    function int unsigned pattern_span();
      return (pat_len > 8) ? 8 : pat_len;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // any register write drops the window and the count
    function void write_reg(sfr_pkg::cfg_reg_t idx, logic [63:0] val);
      case (idx)
        sfr_pkg::REG_PATTERN_BYTES:      pattern = val;
        sfr_pkg::REG_PATTERN_LENGTH:     pat_len = val[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  replacement = val;
        sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len = val[3:0];
        default: ;
      endcase
      fill  = 0;
      total = '0;
    endfunction

    function sfr_pkg::out_beat_t text_beat(logic [7:0] b);
      sfr_pkg::out_beat_t r;
      r            = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      return r;
    endfunction

    // work out the result beats caused by one accepted input beat
    function void note_input(sfr_pkg::in_beat_t beat);
      int unsigned          plen_eff;
      int unsigned          rlen_eff;
      int unsigned          k;
      int                   tail;
      bit                   hit;
      sfr_pkg::out_beat_t   step_q [$];
      plen_eff = pattern_span();
      rlen_eff = (rep_len > 8) ? 8 : rep_len;
      if (plen_eff == 0) begin
        fill = 0;
        step_q.insert(step_q.size(), text_beat(beat.in_byte));
      end else begin
        if (fill >= plen_eff) fill = 0;
        window[fill] = beat.in_byte;
        fill++;
        if (fill == plen_eff) begin
          hit = 1'b1;
          for (k = 0; k < plen_eff; k++)
            if (window[k] != pattern[8*k +: 8]) hit = 1'b0;
          if (hit) begin
            if (total != '1) total++;
            for (k = 0; k < rlen_eff; k++)
              step_q.insert(step_q.size(), text_beat(replacement[8*k +: 8]));
            fill = 0;
          end else begin
            step_q.insert(step_q.size(), text_beat(window[0]));
            for (k = 1; k < fill; k++) window[k-1] = window[k];
            fill--;
          end
        end
      end
      // end of stream flushes the window and carries the count
      if (beat.in_last) begin
        for (k = 0; k < fill; k++) step_q.insert(step_q.size(), text_beat(window[k]));
        if (step_q.size() == 0) step_q.insert(0, '0);
        tail = step_q.size() - 1;
        step_q[tail].out_last    = 1'b1;
        step_q[tail].match_count = total;
        fill  = 0;
        total = '0;
      end
      foreach (step_q[i]) expected_beats.insert(expected_beats.size(), step_q[i]);
    endfunction

    function void check_result(sfr_pkg::out_beat_t got);
      sfr_pkg::out_beat_t want;
      want = '0;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: byte=%h valid=%b last=%b count=%0d",
                   got.out_byte, got.byte_valid, got.out_last, got.match_count);
        return;
      end
      want = expected_beats.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected byte=%h valid=%b last=%b count=%0d,",
                    " got byte=%h valid=%b last=%b count=%0d"},
                   want.out_byte, want.byte_valid, want.out_last, want.match_count,
                   got.out_byte, got.byte_valid, got.out_last, got.match_count);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;

  sfr_in_if  in_chan ();
  sfr_out_if out_chan ();

  stream_find_replace_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  replace_checker chk;
  int             send_idle_pct;
  int             recv_stall_pct;
  int unsigned    cycle_count;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) chk.note_input(in_chan.data);
      if (out_chan.valid && out_chan.ready) chk.check_result(out_chan.data);
    end
  end

  // one register write, starting and ending just after a falling edge
  task automatic write_reg(sfr_pkg::cfg_reg_t idx, logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    chk.write_reg(idx, val);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one input beat, with random sender idling ahead of it
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid        = 1'b1;
    in_chan.data.in_byte = b;
    in_chan.data.in_last = last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every owed beat is out and the pipeline settles
  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 50) return chk.pattern[8*$urandom_range(7) +: 8];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] pick_pattern();
    logic [63:0] p;
    logic [7:0]  alphabet [4];
    alphabet = '{8'h00, 8'hFF, 8'h61, 8'h62};
    p = {$urandom, $urandom};
    if ($urandom_range(1) == 0)
      for (int i = 0; i < 8; i++) p[8*i +: 8] = alphabet[$urandom_range(3)];
    return p;
  endfunction

  // new pattern, replacement and lengths, extremes weighted in
  task automatic random_setup();
    logic [3:0] plen;
    logic [3:0] rlen;
    case ($urandom_range(9))
      0: plen = 4'd0;
      1: plen = 4'd8;
      2: plen = 4'd15;
      3: plen = 4'($urandom_range(9, 14));
      default: plen = 4'($urandom_range(1, 4));
    endcase
    case ($urandom_range(9))
      0: rlen = 4'd0;
      1: rlen = 4'd8;
      2: rlen = 4'd15;
      3: rlen = 4'($urandom_range(9, 14));
      default: rlen = 4'($urandom_range(1, 7));
    endcase
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pick_pattern());
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen});
  endtask

  // mostly whole pattern copies, some broken prefixes and stray bytes
  task automatic run_segment(int n_items, bit hold_mid);
    int          sent;
    int          sel;
    int          run;
    int unsigned plen_eff;
    bit          brk;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      plen_eff = chk.pattern_span();
      sel = $urandom_range(99);
      if (sel < 45 && plen_eff > 0) begin
        run = plen_eff;
        brk = 1'b0;
      end else if (sel < 65 && plen_eff > 1) begin
        run = $urandom_range(1, plen_eff - 1) + 1;
        brk = 1'b1;
      end else begin
        run = 1;
        brk = 1'b1;
      end
      for (int i = 0; i < run; i++) begin
        b = (brk && i == run - 1) ? pick_byte() : chk.pattern[8*i +: 8];
        send_byte(b, $urandom_range(14) == 0);
        sent++;
        if (hold_mid && sent == n_items / 2) drain_results();
      end
    end
  endtask

  initial begin
    chk            = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = sfr_pkg::REG_PATTERN_BYTES;
    cfg_data       = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset setup: single zero byte pattern, matches deleted, empty final flush
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();

    // two byte pattern, oversized replacement length, trailing partial flushed
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0000_6261);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'hFFEE_DDCC_BBAA_9988);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);
    drain_results();

    // zero pattern length passes bytes straight through
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // oversized pattern length saturates to the full eight bytes
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0706_0504_0302_0100);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd1);
    for (int i = 0; i < 8; i++) send_byte(8'(i), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // write in the middle of a stream discards the held window
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    drain_results();
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    send_byte(8'h02, 1'b1);

    // random part over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain_results();
        random_setup();
        run_segment(20, seg == 2);
      end
    end

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (chk.mismatches == 0 && chk.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
